### rtl/core/bmhpq_pkg.sv
`timescale 1ns / 1ps

package bmhpq_pkg;

  localparam int unsigned STATUS_BITS = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // control part of the request that walks down the level chain
  typedef struct packed {
    logic vld;
    logic rmv;
    logic shift;
  } hop_ctl_t;

endpackage

### rtl/core/bmhpq_if.sv
`timescale 1ns / 1ps

interface bmhpq_req_if #(
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [VALUE_BITS-1:0]    item_value;
  logic [PRIORITY_BITS-1:0] item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface bmhpq_rsp_if #(
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned FILL_BITS     = 7
);
  logic                                valid;
  logic                                ready;
  logic [VALUE_BITS-1:0]               out_value;
  logic [PRIORITY_BITS-1:0]            out_priority;
  logic [bmhpq_pkg::STATUS_BITS-1:0]   status;
  logic [FILL_BITS-1:0]                fill_level;

  modport source (output valid, out_value, out_priority, status, fill_level, input ready);
  modport sink   (input valid, out_value, out_priority, status, fill_level, output ready);
endinterface

### rtl/core/bmhpq_cell.sv
`timescale 1ns / 1ps

module bmhpq_cell #(
  parameter int unsigned LVL           = 0,
  parameter int unsigned HEAP_DEPTH    = 64,
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16,
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1),
  localparam int unsigned EW = VALUE_BITS + PRIORITY_BITS,
  localparam int unsigned LW = $clog2(CW)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmhpq_pkg::hop_ctl_t up_ctl_i,
  input  logic [CW-1:0]       up_node_i,
  input  logic [EW-1:0]       up_ent_i,
  output bmhpq_pkg::hop_ctl_t dn_ctl_o,
  output logic [CW-1:0]       dn_node_o,
  output logic [EW-1:0]       dn_ent_o,
  input  logic                wb_vld_i,
  input  logic [CW-1:0]       wb_node_i,
  input  logic [EW-1:0]       wb_ent_i,
  output logic                wb_vld_o,
  output logic [CW-1:0]       wb_node_o,
  output logic [EW-1:0]       wb_ent_o,
  input  logic                peek_vld_i,
  input  logic [CW-1:0]       peek_node_i,
  output logic [EW-1:0]       rd_lo_o,
  output logic [EW-1:0]       rd_hi_o,
  input  logic [CW-1:0]       count_i,
  input  logic [CW-1:0]       leaf_node_i,
  input  logic [LW-1:0]       leaf_lvl_i,
  output logic                fin_o
);
  import bmhpq_pkg::*;

  localparam int unsigned AW = (LVL >= 2) ? LVL - 1 : 1;
  localparam int unsigned TOP_NODE =
      (((2 ** (LVL + 1)) - 1) < HEAP_DEPTH) ? (2 ** (LVL + 1)) - 1 : HEAP_DEPTH;
  localparam int unsigned NROWS_USED = ((TOP_NODE >> 1) & ((2 ** AW) - 1)) + 1;
  localparam int unsigned NROWS = (NROWS_USED < 2) ? 2 : NROWS_USED;
  localparam int unsigned RAW = $clog2(NROWS);
  localparam bit LAST = (LVL == CW - 1);

  // sibling pairs: even node in lo, odd node in hi
  logic [EW-1:0] mem_lo [NROWS];
  logic [EW-1:0] mem_hi [NROWS];

  logic [EW-1:0] rd_lo_q, rd_hi_q;
  logic          tok_vld_q, tok_rmv_q, tok_shift_q;
  logic [CW-1:0] tok_node_q;
  logic [EW-1:0] tok_ent_q;

  logic [RAW-1:0]           raddr;
  logic [EW-1:0]            cur_ent;
  logic [PRIORITY_BITS-1:0] car_pri, cur_pri, lo_pri, hi_pri, best_pri;
  logic                     is_leaf, take;
  logic                     l_ok, r_ok, l_win, r_win, pick;
  logic [CW-1:0]            c_node;
  logic [LW-1:0]            shamt;
  logic                     ins_act, rm_act;
  logic                     own_we;
  logic [CW-1:0]            own_node;
  logic                     we;
  logic [CW-1:0]            wnode;
  logic [EW-1:0]            wdata;

  assign raddr = peek_vld_i ? peek_node_i[RAW:1] : up_node_i[RAW:1];

  always_ff @(posedge clk_i) begin
    rd_lo_q <= mem_lo[raddr];
    rd_hi_q <= mem_hi[raddr];
    if (we) begin
      if (wnode[0]) begin
        mem_hi[wnode[RAW:1]] <= wdata;
      end else begin
        mem_lo[wnode[RAW:1]] <= wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q   <= 1'b0;
      tok_rmv_q   <= 1'b0;
      tok_shift_q <= 1'b0;
      tok_node_q  <= '0;
      tok_ent_q   <= '0;
    end else begin
      tok_vld_q <= up_ctl_i.vld;
      if (up_ctl_i.vld) begin
        tok_rmv_q   <= up_ctl_i.rmv;
        tok_shift_q <= up_ctl_i.shift;
        tok_node_q  <= up_node_i;
        tok_ent_q   <= up_ent_i;
      end
    end
  end

  assign ins_act  = tok_vld_q & ~tok_rmv_q;
  assign rm_act   = tok_vld_q & tok_rmv_q;

  assign cur_ent  = tok_node_q[0] ? rd_hi_q : rd_lo_q;
  assign car_pri  = tok_ent_q[PRIORITY_BITS-1:0];
  assign cur_pri  = cur_ent[PRIORITY_BITS-1:0];
  assign lo_pri   = rd_lo_q[PRIORITY_BITS-1:0];
  assign hi_pri   = rd_hi_q[PRIORITY_BITS-1:0];

  // insert: walk the path to the new leaf, shift the rest down once placed
  assign is_leaf  = (leaf_lvl_i == LW'(LVL));
  assign take     = tok_shift_q | (car_pri < cur_pri);
  assign shamt    = leaf_lvl_i - LW'(LVL + 1);

  // remove: the token node is the left child of the hole
  assign l_ok     = (tok_node_q <= count_i);
  assign r_ok     = ((tok_node_q | CW'(1)) <= count_i);
  assign l_win    = l_ok & (lo_pri < car_pri);
  assign best_pri = l_win ? lo_pri : car_pri;
  assign r_win    = r_ok & (hi_pri < best_pri);
  assign pick     = l_win | r_win;
  assign c_node   = r_win ? (tok_node_q | CW'(1)) : tok_node_q;

  assign own_we   = (ins_act & (is_leaf | take)) | (rm_act & pick & LAST);
  assign own_node = tok_rmv_q ? c_node : tok_node_q;

  assign we    = wb_vld_i | own_we;
  assign wnode = wb_vld_i ? wb_node_i : own_node;
  assign wdata = wb_vld_i ? wb_ent_i : tok_ent_q;

  always_comb begin
    dn_ctl_o  = '0;
    dn_node_o = '0;
    dn_ent_o  = tok_ent_q;
    if (ins_act && !is_leaf) begin
      dn_ctl_o.vld   = 1'b1;
      dn_ctl_o.shift = take;
      dn_node_o      = leaf_node_i >> shamt;
      dn_ent_o       = take ? cur_ent : tok_ent_q;
    end else if (rm_act && pick && !LAST) begin
      dn_ctl_o.vld = 1'b1;
      dn_ctl_o.rmv = 1'b1;
      dn_node_o    = {c_node[CW-2:0], 1'b0};
    end
  end

  assign wb_vld_o  = rm_act;
  assign wb_node_o = tok_node_q >> 1;
  assign wb_ent_o  = pick ? (r_win ? rd_hi_q : rd_lo_q) : tok_ent_q;

  assign fin_o = (ins_act & is_leaf) | (rm_act & (~pick | LAST));

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;

endmodule

### rtl/core/binary_min_heap_priority_queue.sv
// Binary min-heap priority queue of value and priority pairs.
// Requests arrive on req_i (valid/ready): req_type selects insert or remove,
// item_value and item_priority carry the entry to insert. Each request
// returns one response on rsp_o (valid/ready) with the removed entry (zero
// for inserts and errors), a status of ok, empty or full, and the fill level
// after the request.
// The heap is held as a chain of level cells, one per tree level, each with
// its own sibling-pair memory. A request walks the chain one level per cycle.
// An empty or full error goes straight to the response. An insert walks
// the path from the root to the new leaf; a remove first reads the root and
// the last entry, then sinks the last entry down from the root along the level
// chain, with no walk for the remove that empties the heap. One request is
// handled at a time; req_i.ready is high while no request is in flight, so
// req_i.ready rises in the same cycle that the response is presented.
// A response held by a stalled receiver stays in the output register; the
// next request is still taken and its response waits until the register
// frees up.
// Reset empties the heap at once; heap memories are not cleared and entries
// beyond the fill level are never used.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH    = 64,
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmhpq_req_if.sink   req_i,
  bmhpq_rsp_if.source rsp_o
);
  import bmhpq_pkg::*;

  localparam int unsigned CW   = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned EW   = VALUE_BITS + PRIORITY_BITS;
  localparam int unsigned LW   = $clog2(CW);
  localparam int unsigned NLVL = CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_GRAB,
    S_BUSY,
    S_FIN
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            m_q;
  logic [LW-1:0]            d_q;
  logic                     ins_vld_q, rm_vld_q, peek_vld_q;
  logic [EW-1:0]            tok_ent_q;
  logic [VALUE_BITS-1:0]    res_val_q;
  logic [PRIORITY_BITS-1:0] res_pri_q;
  status_e                  res_st_q;
  logic                     out_vld_q;
  logic [VALUE_BITS-1:0]    out_val_q;
  logic [PRIORITY_BITS-1:0] out_pri_q;
  status_e                  out_st_q;
  logic [CW-1:0]            out_fill_q;

  hop_ctl_t      up_ctl  [NLVL];
  logic [CW-1:0] up_node [NLVL];
  logic [EW-1:0] up_ent  [NLVL];
  hop_ctl_t      dn_ctl  [NLVL];
  logic [CW-1:0] dn_node [NLVL];
  logic [EW-1:0] dn_ent  [NLVL];
  logic          wb_vld  [NLVL];
  logic [CW-1:0] wb_node [NLVL];
  logic [EW-1:0] wb_ent  [NLVL];
  logic          wbi_vld [NLVL];
  logic [CW-1:0] wbi_node[NLVL];
  logic [EW-1:0] wbi_ent [NLVL];
  logic [EW-1:0] rd_lo   [NLVL];
  logic [EW-1:0] rd_hi   [NLVL];
  logic [NLVL-1:0] fin_vec;

  logic          req_acc;
  logic [CW-1:0] cnt_inc;
  logic [EW-1:0] last_ent;

  function automatic logic [LW-1:0] lvl_of(input logic [CW-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid & req_i.ready;
  assign cnt_inc     = count_q + CW'(1);

  for (genvar l = 0; l < NLVL; l++) begin : g_lvl
    if (l == 0) begin : g_head
      assign up_ctl[l]  = hop_ctl_t'{vld: ins_vld_q, rmv: 1'b0, shift: 1'b0};
      assign up_node[l] = CW'(1);
      assign up_ent[l]  = tok_ent_q;
    end else if (l == 1) begin : g_first
      assign up_ctl[l]  = rm_vld_q ? hop_ctl_t'{vld: 1'b1, rmv: 1'b1, shift: 1'b0}
                                   : dn_ctl[l-1];
      assign up_node[l] = rm_vld_q ? CW'(2) : dn_node[l-1];
      assign up_ent[l]  = rm_vld_q ? tok_ent_q : dn_ent[l-1];
    end else begin : g_mid
      assign up_ctl[l]  = dn_ctl[l-1];
      assign up_node[l] = dn_node[l-1];
      assign up_ent[l]  = dn_ent[l-1];
    end

    if (l == NLVL - 1) begin : g_tail
      assign wbi_vld[l]  = 1'b0;
      assign wbi_node[l] = '0;
      assign wbi_ent[l]  = '0;
    end else begin : g_wb
      assign wbi_vld[l]  = wb_vld[l+1];
      assign wbi_node[l] = wb_node[l+1];
      assign wbi_ent[l]  = wb_ent[l+1];
    end

    bmhpq_cell #(
      .LVL           (l),
      .HEAP_DEPTH    (HEAP_DEPTH),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .up_ctl_i    (up_ctl[l]),
      .up_node_i   (up_node[l]),
      .up_ent_i    (up_ent[l]),
      .dn_ctl_o    (dn_ctl[l]),
      .dn_node_o   (dn_node[l]),
      .dn_ent_o    (dn_ent[l]),
      .wb_vld_i    (wbi_vld[l]),
      .wb_node_i   (wbi_node[l]),
      .wb_ent_i    (wbi_ent[l]),
      .wb_vld_o    (wb_vld[l]),
      .wb_node_o   (wb_node[l]),
      .wb_ent_o    (wb_ent[l]),
      .peek_vld_i  (peek_vld_q),
      .peek_node_i ((l == 0) ? CW'(1) : m_q),
      .rd_lo_o     (rd_lo[l]),
      .rd_hi_o     (rd_hi[l]),
      .count_i     (count_q),
      .leaf_node_i (m_q),
      .leaf_lvl_i  (d_q),
      .fin_o       (fin_vec[l])
    );
  end

  // last entry of the heap before a remove
  always_comb begin
    last_ent = rd_hi[0];
    for (int l = 0; l < NLVL; l++) begin
      if (d_q == LW'(l)) begin
        last_ent = m_q[0] ? rd_hi[l] : rd_lo[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      m_q        <= '0;
      d_q        <= '0;
      ins_vld_q  <= 1'b0;
      rm_vld_q   <= 1'b0;
      peek_vld_q <= 1'b0;
      tok_ent_q  <= '0;
      res_val_q  <= '0;
      res_pri_q  <= '0;
      res_st_q   <= ST_OK;
      out_vld_q  <= 1'b0;
      out_val_q  <= '0;
      out_pri_q  <= '0;
      out_st_q   <= ST_OK;
      out_fill_q <= '0;
    end else begin
      ins_vld_q  <= 1'b0;
      rm_vld_q   <= 1'b0;
      peek_vld_q <= 1'b0;
      if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            res_val_q <= '0;
            res_pri_q <= '0;
            res_st_q  <= ST_OK;
            if (req_i.req_type == REQ_INSERT) begin
              if (count_q == CW'(HEAP_DEPTH)) begin
                res_st_q <= ST_FULL;
                state_q  <= S_FIN;
              end else begin
                ins_vld_q <= 1'b1;
                tok_ent_q <= {req_i.item_value, req_i.item_priority};
                m_q       <= cnt_inc;
                d_q       <= lvl_of(cnt_inc);
                count_q   <= cnt_inc;
                state_q   <= S_BUSY;
              end
            end else begin
              if (count_q == '0) begin
                res_st_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                peek_vld_q <= 1'b1;
                m_q        <= count_q;
                d_q        <= lvl_of(count_q);
                count_q    <= count_q - CW'(1);
                state_q    <= S_PEEK;
              end
            end
          end
        end
        S_PEEK: begin
          state_q <= S_GRAB;
        end
        S_GRAB: begin
          res_val_q <= rd_hi[0][EW-1:PRIORITY_BITS];
          res_pri_q <= rd_hi[0][PRIORITY_BITS-1:0];
          tok_ent_q <= last_ent;
          if (count_q != '0) begin
            rm_vld_q <= 1'b1;
            state_q  <= S_BUSY;
          end else begin
            state_q  <= S_FIN;
          end
        end
        S_BUSY: begin
          if (|fin_vec) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q  <= 1'b1;
            out_val_q  <= res_val_q;
            out_pri_q  <= res_pri_q;
            out_st_q   <= res_st_q;
            out_fill_q <= count_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.out_value    = out_val_q;
  assign rsp_o.out_priority = out_pri_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.fill_level   = out_fill_q;

  a_root_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wb_vld[0])
    else $error("write-back above the root");

  a_tail_no_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dn_ctl[NLVL-1].vld)
    else $error("request passed below the last level");

  a_one_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fin_vec))
    else $error("more than one level finished");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|fin_vec) |-> (state_q == S_BUSY))
    else $error("level finished outside a walk");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HEAP_DEPTH))
    else $error("fill level beyond depth");

endmodule
